>>> hdl/indexed_sequence_store_assert.svh
`ifndef INDEXED_SEQUENCE_STORE_ASSERT_SVH
`define INDEXED_SEQUENCE_STORE_ASSERT_SVH

// same-cycle check, clocked on clk and quiet while rst_n is low
`define ISQS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("indexed_sequence_store: same-cycle check failed");

// next-cycle check, clocked on clk and quiet while rst_n is low
`define ISQS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("indexed_sequence_store: next-cycle check failed");

`endif

>>> hdl/isqs_pkg.sv
package isqs_pkg;

  localparam int CAPACITY = 64;
  localparam int AW       = $clog2(CAPACITY);
  localparam int CW       = 7;
  localparam int IW       = 7;
  localparam int DW       = 32;
  localparam int SW       = 2;
  localparam int OPW      = 4;
  localparam int KW       = 4;
  localparam int QDEPTH   = 2;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  localparam logic [OPW-1:0] OP_PUSH_FRONT  = 4'd0;
  localparam logic [OPW-1:0] OP_PUSH_BACK   = 4'd1;
  localparam logic [OPW-1:0] OP_POP_FRONT   = 4'd2;
  localparam logic [OPW-1:0] OP_POP_BACK    = 4'd3;
  localparam logic [OPW-1:0] OP_INSERT_AFTER = 4'd4;
  localparam logic [OPW-1:0] OP_ERASE       = 4'd5;
  localparam logic [OPW-1:0] OP_READ        = 4'd6;
  localparam logic [OPW-1:0] OP_WRITE       = 4'd7;
  localparam logic [OPW-1:0] OP_ADD_ALL     = 4'd8;
  localparam logic [OPW-1:0] OP_RESIZE      = 4'd9;

  localparam logic [SW-1:0] ST_OK    = 2'd0;
  localparam logic [SW-1:0] ST_EMPTY = 2'd1;
  localparam logic [SW-1:0] ST_RANGE = 2'd2;
  localparam logic [SW-1:0] ST_FULL  = 2'd3;

  // request classes handed from the front to the back
  localparam logic [KW-1:0] K_NOP    = 4'd0;
  localparam logic [KW-1:0] K_PUSH   = 4'd1;
  localparam logic [KW-1:0] K_INSERT = 4'd2;
  localparam logic [KW-1:0] K_POP    = 4'd3;
  localparam logic [KW-1:0] K_ERASE  = 4'd4;
  localparam logic [KW-1:0] K_READ   = 4'd5;
  localparam logic [KW-1:0] K_WRITE  = 4'd6;
  localparam logic [KW-1:0] K_ADD    = 4'd7;
  localparam logic [KW-1:0] K_RESIZE = 4'd8;

  typedef struct packed {
    logic [KW-1:0] kind;
    logic          at_back;
    logic          too_big;
    logic [IW-1:0] index;
    logic [DW-1:0] value;
  } cmd_t;

endpackage

>>> hdl/isqs_front.sv
module isqs_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [isqs_pkg::IN_TDATA_W-1:0]    in_tdata,   // index[6:0], value[38:7], zero pad
  input  logic [isqs_pkg::OPW-1:0]           in_tuser,   // opcode[3:0]
  output logic                               cmd_valid,
  input  logic                               cmd_ready,
  output isqs_pkg::cmd_t                     cmd
);
  import isqs_pkg::*;

  cmd_t cmd_r;
  cmd_t cmd_nxt;
  logic fv_r;
  logic fv_nxt;
  logic take;

  assign in_tready = !fv_r || cmd_ready;
  assign take      = in_tvalid && in_tready;
  assign cmd_valid = fv_r;
  assign cmd       = cmd_r;

  always_comb begin
    cmd_nxt         = cmd_r;
    fv_nxt          = fv_r && !cmd_ready;
    if (take) begin
      fv_nxt          = 1'b1;
      cmd_nxt.index   = in_tdata[IW-1:0];
      cmd_nxt.value   = in_tdata[IW+DW-1:IW];
      cmd_nxt.too_big = in_tdata[IW-1:0] > CW'(CAPACITY);
      cmd_nxt.at_back = 1'b0;
      unique case (in_tuser)
        OP_PUSH_FRONT:   cmd_nxt.kind = K_PUSH;
        OP_PUSH_BACK: begin
          cmd_nxt.kind    = K_PUSH;
          cmd_nxt.at_back = 1'b1;
        end
        OP_POP_FRONT:    cmd_nxt.kind = K_POP;
        OP_POP_BACK: begin
          cmd_nxt.kind    = K_POP;
          cmd_nxt.at_back = 1'b1;
        end
        OP_INSERT_AFTER: cmd_nxt.kind = K_INSERT;
        OP_ERASE:        cmd_nxt.kind = K_ERASE;
        OP_READ:         cmd_nxt.kind = K_READ;
        OP_WRITE:        cmd_nxt.kind = K_WRITE;
        OP_ADD_ALL:      cmd_nxt.kind = K_ADD;
        OP_RESIZE:       cmd_nxt.kind = K_RESIZE;
        default:         cmd_nxt.kind = K_NOP;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else begin
      fv_r <= fv_nxt;
    end
    cmd_r <= cmd_nxt;
  end

endmodule

>>> hdl/isqs_queue.sv
module isqs_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  isqs_pkg::cmd_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output isqs_pkg::cmd_t pop_data
);
  import isqs_pkg::*;

  localparam int QAW = $clog2(QDEPTH);
  localparam int QCW = $clog2(QDEPTH + 1);

  cmd_t           slot_r [QDEPTH];
  logic [QAW-1:0] wp_r;
  logic [QAW-1:0] wp_nxt;
  logic [QAW-1:0] rp_r;
  logic [QAW-1:0] rp_nxt;
  logic [QCW-1:0] cnt_r;
  logic [QCW-1:0] cnt_nxt;
  logic           do_push;
  logic           do_pop;

  assign push_ready = cnt_r != QCW'(QDEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_data   = slot_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == QAW'(QDEPTH - 1)) ? '0 : wp_r + QAW'(1);
    end
    if (do_pop) begin
      rp_nxt = (rp_r == QAW'(QDEPTH - 1)) ? '0 : rp_r + QAW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + QCW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) begin
      slot_r[wp_r] <= push_data;
    end
  end

endmodule

>>> hdl/isqs_back.sv
module isqs_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cmd_valid,
  output logic                             cmd_ready,
  input  isqs_pkg::cmd_t                   cmd,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [isqs_pkg::OUT_TDATA_W-1:0] out_tdata,  // read_data[31:0], count[38:32], zero pad
  output logic [isqs_pkg::SW-1:0]          out_tuser   // status[1:0]
);
  import isqs_pkg::*;
  `include "indexed_sequence_store_assert.svh"

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SHUP = 3'd1;
  localparam logic [2:0] S_SHDN = 3'd2;
  localparam logic [2:0] S_ADD  = 3'd3;
  localparam logic [2:0] S_FILL = 3'd4;
  localparam logic [2:0] S_RDW  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [DW-1:0] mem [CAPACITY];
  logic [DW-1:0] rdata_r;

  logic [2:0]    state_r,  state_nxt;
  logic [CW-1:0] ptr_r,    ptr_nxt;
  logic [CW-1:0] tgt_r,    tgt_nxt;
  logic [CW-1:0] len_r,    len_nxt;
  logic [DW-1:0] val_r,    val_nxt;
  logic          phase_r,  phase_nxt;
  logic [DW-1:0] rd_r,     rd_nxt;
  logic [SW-1:0] st_r,     st_nxt;
  logic          ov_r,     ov_nxt;
  logic [DW-1:0] odata_r,  odata_nxt;
  logic [CW-1:0] ocount_r, ocount_nxt;
  logic [SW-1:0] ostat_r,  ostat_nxt;

  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [DW-1:0] mem_wd;
  logic [AW-1:0] mem_ra;

  logic [CW-1:0] ptr_inc;
  logic [CW-1:0] ptr_dec;
  logic [CW-1:0] len_dec;
  logic [CW-1:0] tgt_ins;
  logic          empty;
  logic          full;
  logic          in_range;
  logic          slot_free;

  assign ptr_inc   = ptr_r + CW'(1);
  assign ptr_dec   = ptr_r - CW'(1);
  assign len_dec   = len_r - CW'(1);
  assign tgt_ins   = cmd.index + CW'(1);
  assign empty     = len_r == '0;
  assign full      = len_r == CW'(CAPACITY);
  assign in_range  = cmd.index < len_r;
  assign slot_free = !ov_r || out_tready;

  assign cmd_ready  = state_r == S_IDLE;
  assign out_tvalid = ov_r;
  assign out_tdata  = {1'b0, ocount_r, odata_r};
  assign out_tuser  = ostat_r;

  always_comb begin
    state_nxt  = state_r;
    ptr_nxt    = ptr_r;
    tgt_nxt    = tgt_r;
    len_nxt    = len_r;
    val_nxt    = val_r;
    phase_nxt  = phase_r;
    rd_nxt     = rd_r;
    st_nxt     = st_r;
    ov_nxt     = ov_r && !out_tready;
    odata_nxt  = odata_r;
    ocount_nxt = ocount_r;
    ostat_nxt  = ostat_r;
    mem_we     = 1'b0;
    mem_wa     = '0;
    mem_wd     = '0;
    mem_ra     = '0;

    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          rd_nxt    = '0;
          st_nxt    = ST_OK;
          val_nxt   = cmd.value;
          phase_nxt = 1'b0;
          state_nxt = S_DONE;
          unique case (cmd.kind)
            K_PUSH: begin
              if (full) begin
                st_nxt = ST_FULL;
              end else begin
                ptr_nxt   = len_r;
                tgt_nxt   = cmd.at_back ? len_r : '0;
                state_nxt = S_SHUP;
              end
            end
            K_INSERT: begin
              priority if (empty) begin
                st_nxt = ST_EMPTY;
              end else if (!in_range) begin
                st_nxt = ST_RANGE;
              end else if (full) begin
                st_nxt = ST_FULL;
              end else begin
                ptr_nxt   = len_r;
                tgt_nxt   = tgt_ins;
                state_nxt = S_SHUP;
              end
            end
            K_POP: begin
              if (empty) begin
                st_nxt = ST_EMPTY;
              end else begin
                ptr_nxt   = cmd.at_back ? len_dec : '0;
                state_nxt = S_SHDN;
              end
            end
            K_ERASE, K_READ, K_WRITE: begin
              priority if (empty) begin
                st_nxt = ST_EMPTY;
              end else if (!in_range) begin
                st_nxt = ST_RANGE;
              end else if (cmd.kind == K_ERASE) begin
                ptr_nxt   = cmd.index;
                state_nxt = S_SHDN;
              end else if (cmd.kind == K_READ) begin
                mem_ra    = cmd.index[AW-1:0];
                state_nxt = S_RDW;
              end else begin
                mem_we = 1'b1;
                mem_wa = cmd.index[AW-1:0];
                mem_wd = cmd.value;
              end
            end
            K_ADD: begin
              if (empty) begin
                st_nxt = ST_EMPTY;
              end else begin
                ptr_nxt   = '0;
                state_nxt = S_ADD;
              end
            end
            K_RESIZE: begin
              priority if (cmd.too_big) begin
                st_nxt = ST_FULL;
              end else if (cmd.index > len_r) begin
                ptr_nxt   = len_r;
                tgt_nxt   = cmd.index;
                state_nxt = S_FILL;
              end else begin
                len_nxt = cmd.index;
              end
            end
            default: ;
          endcase
        end
      end

      // move the tail up one slot, highest element first
      S_SHUP: begin
        if (!phase_r) begin
          if (ptr_r == tgt_r) begin
            mem_we    = 1'b1;
            mem_wa    = tgt_r[AW-1:0];
            mem_wd    = val_r;
            len_nxt   = len_r + CW'(1);
            state_nxt = S_DONE;
          end else begin
            mem_ra    = ptr_dec[AW-1:0];
            phase_nxt = 1'b1;
          end
        end else begin
          mem_we    = 1'b1;
          mem_wa    = ptr_r[AW-1:0];
          mem_wd    = rdata_r;
          ptr_nxt   = ptr_dec;
          phase_nxt = 1'b0;
        end
      end

      // move the tail down one slot, lowest element first
      S_SHDN: begin
        if (!phase_r) begin
          if (ptr_inc == len_r) begin
            len_nxt   = len_dec;
            state_nxt = S_DONE;
          end else begin
            mem_ra    = ptr_inc[AW-1:0];
            phase_nxt = 1'b1;
          end
        end else begin
          mem_we    = 1'b1;
          mem_wa    = ptr_r[AW-1:0];
          mem_wd    = rdata_r;
          ptr_nxt   = ptr_inc;
          phase_nxt = 1'b0;
        end
      end

      S_ADD: begin
        if (!phase_r) begin
          mem_ra    = ptr_r[AW-1:0];
          phase_nxt = 1'b1;
        end else begin
          mem_we    = 1'b1;
          mem_wa    = ptr_r[AW-1:0];
          mem_wd    = rdata_r + val_r;
          phase_nxt = 1'b0;
          if (ptr_r == len_dec) begin
            state_nxt = S_DONE;
          end else begin
            ptr_nxt = ptr_inc;
          end
        end
      end

      // zero the new positions on growth
      S_FILL: begin
        if (ptr_r == tgt_r) begin
          len_nxt   = tgt_r;
          state_nxt = S_DONE;
        end else begin
          mem_we  = 1'b1;
          mem_wa  = ptr_r[AW-1:0];
          mem_wd  = '0;
          ptr_nxt = ptr_inc;
        end
      end

      S_RDW: begin
        rd_nxt    = rdata_r;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (slot_free) begin
          ov_nxt     = 1'b1;
          odata_nxt  = rd_r;
          ocount_nxt = len_r;
          ostat_nxt  = st_r;
          state_nxt  = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      len_r   <= '0;
      ov_r    <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      ov_r    <= ov_nxt;
      phase_r <= phase_nxt;
    end
    ptr_r    <= ptr_nxt;
    tgt_r    <= tgt_nxt;
    val_r    <= val_nxt;
    rd_r     <= rd_nxt;
    st_r     <= st_nxt;
    odata_r  <= odata_nxt;
    ocount_r <= ocount_nxt;
    ostat_r  <= ostat_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_r <= mem[mem_ra];
  end

  `ISQS_ASSERT_NOW(a_len_bound, 1'b1, len_r <= CW'(CAPACITY))
  `ISQS_ASSERT_NOW(a_shup_ptr, state_r == S_SHUP, ptr_r >= tgt_r && ptr_r < CW'(CAPACITY))
  `ISQS_ASSERT_NOW(a_shdn_ptr, state_r == S_SHDN, ptr_r < len_r)
  `ISQS_ASSERT_NEXT(a_done_out, state_r == S_DONE && slot_free, ov_r && state_r == S_IDLE)
  `ISQS_ASSERT_NEXT(a_fill_grow, state_r == S_FILL && ptr_r == tgt_r, len_r == $past(tgt_r))

endmodule

>>> hdl/indexed_sequence_store.sv
// path: a request passes the front register, the request queue, the back-end state machine
//   and the output register; reads also pass a read-wait state, shifting requests read and
//   write each moved element in turn, add_all reads and writes every element, a growing resize writes each new one
// throughput: one request at a time in the back end, which takes no new request until it
//   is back in idle; output back-pressure can hold it in its done state
// reset: synchronous active-low rst_n empties the store (count 0) and drops queued requests
module indexed_sequence_store (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [isqs_pkg::IN_TDATA_W-1:0]  in_tdata,   // index[6:0], value[38:7], zero pad
  input  logic [isqs_pkg::OPW-1:0]         in_tuser,   // opcode[3:0]
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [isqs_pkg::OUT_TDATA_W-1:0] out_tdata,  // read_data[31:0], count[38:32], zero pad
  output logic [isqs_pkg::SW-1:0]          out_tuser   // status[1:0]
);
  import isqs_pkg::*;

  cmd_t f_cmd;
  logic f_valid;
  logic f_ready;
  cmd_t b_cmd;
  logic b_valid;
  logic b_ready;

  isqs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  isqs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_cmd),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (b_cmd)
  );

  isqs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (b_valid),
    .cmd_ready  (b_ready),
    .cmd        (b_cmd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
